@@ hw/rtl/pts_pkg.sv @@
// Shared types and constants of the priority time-slice scheduler.
// No dependencies; imported by every module of the block.
package pts_pkg;

  localparam int unsigned SlotFieldW = 4;
  localparam int unsigned PrioW      = 8;
  localparam int unsigned CntW       = 9;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned SecW       = 16;

  localparam logic [9:0] MsPerSec = 10'd1000;

  // Request codes on the input channel
  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_SLEEP   = 3'd1;
  localparam logic [2:0] REQ_YIELD   = 3'd2;
  localparam logic [2:0] REQ_INSTALL = 3'd3;
  localparam logic [2:0] REQ_EXIT    = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_TICK,
    OP_SLEEP,
    OP_YIELD,
    OP_INSTALL,
    OP_EXIT
  } op_e;

  typedef enum logic [1:0] {
    ST_READY   = 2'd0,
    ST_RUNNING = 2'd1,
    ST_SLEEP   = 2'd2,
    ST_EXITED  = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]            req_type;
    logic [TimeW-1:0]      now_ms;
    logic [SlotFieldW-1:0] slot;
    logic [PrioW-1:0]      task_priority;
    logic [SecW-1:0]       sleep_seconds;
  } req_t;

  typedef struct packed {
    logic                  switched;
    logic [SlotFieldW-1:0] next_slot;
    logic [CntW-1:0]       next_counter;
    logic                  recomputed;
    logic                  idle_fallback;
  } res_t;

  // Classified request passed from the front end to the engine
  typedef struct packed {
    op_e                   op;
    logic [TimeW-1:0]      now_ms;
    logic [TimeW-1:0]      wake_ms;
    logic [SlotFieldW-1:0] slot;
    logic                  in_range;
    logic [PrioW-1:0]      prio;
  } cmd_t;

endpackage

@@ hw/rtl/pts_front.sv @@
// Front end: accepts request transactions, decodes the kind, checks the slot
// range and precomputes the wake-up time. Depends on pts_pkg.
module pts_front import pts_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic cmd_valid_o,
  input  logic cmd_ready_i,
  output cmd_t cmd_o
);

  logic        stg_valid_q, stg_valid_d;
  cmd_t        stg_q;
  cmd_t        dec;
  logic [25:0] sleep_ms;

  always_comb begin
    dec          = '0;
    sleep_ms     = 26'(in_data_i.sleep_seconds) * 26'(MsPerSec);
    dec.now_ms   = in_data_i.now_ms;
    dec.wake_ms  = in_data_i.now_ms + 32'(sleep_ms);
    dec.slot     = in_data_i.slot;
    dec.in_range = ({28'd0, in_data_i.slot} < 32'(NUM_SLOTS));
    dec.prio     = in_data_i.task_priority;
    case (in_data_i.req_type)
      REQ_TICK:    dec.op = OP_TICK;
      REQ_SLEEP:   dec.op = OP_SLEEP;
      REQ_YIELD:   dec.op = OP_YIELD;
      REQ_INSTALL: dec.op = OP_INSTALL;
      REQ_EXIT:    dec.op = OP_EXIT;
      default:     dec.op = OP_NOP;
    endcase
  end

  assign in_ready_o  = !stg_valid_q || cmd_ready_i;
  assign cmd_valid_o = stg_valid_q;
  assign cmd_o       = stg_q;

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (cmd_ready_i) begin
      stg_valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      stg_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stg_q <= dec;
    end
  end

endmodule

@@ hw/rtl/pts_cmd_fifo.sv @@
// Short command queue between the front end and the engine.
// Depends on pts_pkg for the command type.
module pts_cmd_fifo import pts_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

@@ hw/rtl/pts_engine.sv @@
// Back end: task table memories, scan sequencer and result register.
// Depends on pts_pkg.
module pts_engine import pts_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned IW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_WR,
    S_SCAN,
    S_CHECK,
    S_FIN_RD,
    S_FIN_OUT
  } state_e;

  // Task table, one shared read address and one shared write address
  status_e          status_mem [NUM_SLOTS];
  logic [CntW-1:0]  cnt_mem    [NUM_SLOTS];
  logic [PrioW-1:0] prio_mem   [NUM_SLOTS];
  logic [TimeW-1:0] wake_mem   [NUM_SLOTS];

  status_e          st_rd_q;
  logic [CntW-1:0]  cnt_rd_q;
  logic [PrioW-1:0] prio_rd_q;
  logic [TimeW-1:0] wake_rd_q;

  logic [SW-1:0]    raddr, waddr;
  logic             st_we, cnt_we, prio_we, wake_we;
  status_e          st_wdata;
  logic [CntW-1:0]  cnt_wdata;
  logic [PrioW-1:0] prio_wdata;
  logic [TimeW-1:0] wake_wdata;

  state_e           state_q, state_d;
  logic [NUM_SLOTS-1:0] valid_q, valid_d;
  logic [SW-1:0]    cur_q, cur_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [SW-1:0]    pidx_q, pidx_d;
  logic             proc_q, proc_d;
  logic             pass_q, pass_d;
  logic             found_q, found_d;
  logic [CntW-1:0]  best_cnt_q, best_cnt_d;
  logic [SW-1:0]    best_idx_q, best_idx_d;
  logic [TimeW-1:0] now_q, now_d;
  logic             sw_q, sw_d, rec_q, rec_d, idle_q, idle_d;
  logic             res_valid_q, res_valid_d;
  res_t             res_q, res_d;

  logic [SW-1:0]    sidx;
  logic             eff_ready, recharge, better;
  logic [CntW-1:0]  eff_cnt, new_cnt;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign sidx        = SW'(cmd_i.slot);

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      status_mem[waddr] <= st_wdata;
    end
    if (cnt_we) begin
      cnt_mem[waddr] <= cnt_wdata;
    end
    if (prio_we) begin
      prio_mem[waddr] <= prio_wdata;
    end
    if (wake_we) begin
      wake_mem[waddr] <= wake_wdata;
    end
    st_rd_q   <= status_mem[raddr];
    cnt_rd_q  <= cnt_mem[raddr];
    prio_rd_q <= prio_mem[raddr];
    wake_rd_q <= wake_mem[raddr];
  end

  // Evaluate the entry read in the previous cycle of a scan pass
  always_comb begin
    new_cnt  = 9'(prio_rd_q) + (cnt_rd_q >> 1);
    recharge = 1'b0;
    if (!pass_q) begin
      eff_ready = valid_q[pidx_q] && ((st_rd_q == ST_READY) ||
                  ((st_rd_q == ST_SLEEP) && (now_q > wake_rd_q)));
      eff_cnt   = cnt_rd_q;
    end else begin
      recharge  = valid_q[pidx_q] && (st_rd_q != ST_EXITED);
      eff_ready = valid_q[pidx_q] && (st_rd_q == ST_READY);
      eff_cnt   = recharge ? new_cnt : cnt_rd_q;
    end
    better = eff_ready && (!found_q || (eff_cnt > best_cnt_q));
  end

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    pidx_d      = idx_q[SW-1:0];
    proc_d      = 1'b0;
    pass_d      = pass_q;
    found_d     = found_q;
    best_cnt_d  = best_cnt_q;
    best_idx_d  = best_idx_q;
    now_d       = now_q;
    sw_d        = sw_q;
    rec_d       = rec_q;
    idle_d      = idle_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    raddr       = cur_q;
    waddr       = cur_q;
    st_we       = 1'b0;
    cnt_we      = 1'b0;
    prio_we     = 1'b0;
    wake_we     = 1'b0;
    st_wdata    = ST_SLEEP;
    cnt_wdata   = '0;
    prio_wdata  = cmd_i.prio;
    wake_wdata  = cmd_i.wake_ms;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          now_d      = cmd_i.now_ms;
          sw_d       = 1'b0;
          rec_d      = 1'b0;
          idle_d     = 1'b0;
          idx_d      = '0;
          pass_d     = 1'b0;
          found_d    = 1'b0;
          best_cnt_d = '0;
          best_idx_d = '0;
          state_d    = S_FIN_RD;
          case (cmd_i.op)
            OP_TICK: begin
              // counter of the current slot arrives next cycle
              if (valid_q[cur_q]) begin
                state_d = S_TICK_WR;
              end
            end
            OP_SLEEP: begin
              if (valid_q[cur_q]) begin
                wake_we = 1'b1;
                st_we   = 1'b1;
                sw_d    = 1'b1;
                state_d = S_SCAN;
              end
            end
            OP_YIELD: begin
              sw_d    = 1'b1;
              state_d = S_SCAN;
            end
            OP_INSTALL: begin
              if (cmd_i.in_range) begin
                waddr      = sidx;
                st_we      = 1'b1;
                st_wdata   = ST_READY;
                cnt_we     = 1'b1;
                cnt_wdata  = 9'(cmd_i.prio);
                prio_we    = 1'b1;
                wake_we    = 1'b1;
                wake_wdata = '0;
                valid_d[sidx] = 1'b1;
              end
            end
            OP_EXIT: begin
              if (cmd_i.in_range) begin
                waddr    = sidx;
                st_we    = 1'b1;
                st_wdata = ST_EXITED;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_TICK_WR: begin
        cnt_we = 1'b1;
        if (cnt_rd_q > 9'd1) begin
          cnt_wdata = cnt_rd_q - 9'd1;
          state_d   = S_FIN_RD;
        end else begin
          st_we   = 1'b1;
          sw_d    = 1'b1;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        if (idx_q < IW'(NUM_SLOTS)) begin
          raddr  = idx_q[SW-1:0];
          idx_d  = idx_q + 1'b1;
          proc_d = 1'b1;
        end
        if (proc_q) begin
          waddr = pidx_q;
          if (!pass_q) begin
            // wake a due sleeper in place
            st_we    = valid_q[pidx_q] && (st_rd_q == ST_SLEEP) && (now_q > wake_rd_q);
            st_wdata = ST_READY;
          end else begin
            cnt_we    = recharge;
            cnt_wdata = new_cnt;
          end
          if (better) begin
            found_d    = 1'b1;
            best_cnt_d = eff_cnt;
            best_idx_d = pidx_q;
          end
        end
        if (idx_q == IW'(NUM_SLOTS)) begin
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        if (!pass_q && found_q && (best_cnt_q == '0)) begin
          pass_d     = 1'b1;
          rec_d      = 1'b1;
          idx_d      = '0;
          found_d    = 1'b0;
          best_cnt_d = '0;
          best_idx_d = '0;
          state_d    = S_SCAN;
        end else begin
          st_wdata = ST_RUNNING;
          if (!found_q) begin
            idle_d = 1'b1;
            cur_d  = '0;
            waddr  = '0;
            st_we  = valid_q[0];
          end else begin
            cur_d = best_idx_q;
            waddr = best_idx_q;
            st_we = 1'b1;
          end
          state_d = S_FIN_RD;
        end
      end

      S_FIN_RD: begin
        state_d = S_FIN_OUT;
      end

      S_FIN_OUT: begin
        if (!res_valid_q || res_ready_i) begin
          res_d.switched      = sw_q;
          res_d.next_slot     = 4'(cur_q);
          res_d.next_counter  = valid_q[cur_q] ? cnt_rd_q : '0;
          res_d.recomputed    = rec_q;
          res_d.idle_fallback = idle_q;
          res_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      cur_q       <= '0;
      idx_q       <= '0;
      pidx_q      <= '0;
      proc_q      <= 1'b0;
      pass_q      <= 1'b0;
      found_q     <= 1'b0;
      best_cnt_q  <= '0;
      best_idx_q  <= '0;
      sw_q        <= 1'b0;
      rec_q       <= 1'b0;
      idle_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      cur_q       <= cur_d;
      idx_q       <= idx_d;
      pidx_q      <= pidx_d;
      proc_q      <= proc_d;
      pass_q      <= pass_d;
      found_q     <= found_d;
      best_cnt_q  <= best_cnt_d;
      best_idx_q  <= best_idx_d;
      sw_q        <= sw_d;
      rec_q       <= rec_d;
      idle_q      <= idle_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    res_q <= res_d;
  end

  a_flags_need_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.switched || (!res_q.recomputed && !res_q.idle_fallback)))
    else $error("recharge or fallback flagged without a scheduling decision");

  a_fallback_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.idle_fallback) |-> (res_q.next_slot == '0))
    else $error("idle fallback did not select slot zero");

  a_recharge_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && pass_q) |=> (state_q == S_FIN_RD))
    else $error("second pick did not end the decision");

  a_winner_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && found_q) |-> valid_q[best_idx_q])
    else $error("picked slot is not installed");

endmodule

@@ hw/rtl/priority_timeslice_scheduler.sv @@
// Priority time-slice scheduler over a table of task slots.
//
// Input channel in_valid_i/in_ready_o carries one request (tick, sleep,
// yield, install, exit) with the current time; output channel
// out_valid_o/out_ready_i returns exactly one result per request, in order.
// The front end registers and decodes a request, a two-entry queue decouples
// it from the engine, and the engine handles one request at a time.
// Install, exit and unused kinds and a tick that does not expire need no
// scan. A scheduling request (a yield, a sleep on an installed slot or an
// expiring tick) scans the slot table once, one slot per cycle through the
// single table read port, and a second time when counters are recharged.
// Front end and queue overlap the engine, so they take new requests while
// it is busy with an earlier one.
// Reset empties the queue, clears all valid bits (every slot reads as
// exited) and selects slot 0. No clearing pass runs after reset.
// When the receiver stalls, the result register holds; engine, queue and front
// end still take up to QUEUE_DEPTH + 2 more requests before in_ready_o drops.
// Depends on pts_pkg, pts_front, pts_cmd_fifo and pts_engine.
module priority_timeslice_scheduler import pts_pkg::*; #(
  parameter int unsigned NUM_SLOTS   = 16,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  logic f_valid, f_ready;
  cmd_t f_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  pts_front #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cmd_valid_o(f_valid),
    .cmd_ready_i(f_ready),
    .cmd_o      (f_cmd)
  );

  pts_cmd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .push_data_i (f_cmd),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_data_o  (q_cmd)
  );

  pts_engine #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_ready_o(q_ready),
    .cmd_i      (q_cmd),
    .res_valid_o(out_valid_o),
    .res_ready_i(out_ready_i),
    .res_o      (out_data_o)
  );

endmodule

@@ test/tb_priority_timeslice_scheduler.sv @@
// Self-checking testbench for priority_timeslice_scheduler: directed and random
// request streams with bursty input and stalling output, checked against a slot-table predictor.
// Depends on pts_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module tb_priority_timeslice_scheduler;
  import pts_pkg::*;

  localparam int unsigned NumSlots    = 16;
  localparam int unsigned ResetCycles = 11;
  localparam int unsigned RandomItems = 1000;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned CycleLimit  = 500000;

  localparam logic [2:0] ReqFirstUnused = REQ_EXIT + 3'd1;
  localparam logic [2:0] ReqLastCode    = 3'd7;

  typedef enum int {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  // Slot-table predictor and the queue of results it expects, oldest first.
  class sched_scoreboard;
    res_t                  expected_q[$];
    int unsigned           errors, noted, checked, decisions, recharges, idles;
    logic                  valid_tab[NumSlots];
    status_e               status_tab[NumSlots];
    logic [CntW-1:0]       cnt_tab[NumSlots];
    logic [PrioW-1:0]      prio_tab[NumSlots];
    logic [TimeW-1:0]      wake_tab[NumSlots];
    logic [SlotFieldW-1:0] cur_slot;

    function new();
      for (int i = 0; i < NumSlots; i++) begin
        valid_tab[i]  = 1'b0;
        status_tab[i] = ST_EXITED;
        cnt_tab[i]    = '0;
        prio_tab[i]   = '0;
        wake_tab[i]   = '0;
      end
      cur_slot = '0;
    endfunction

    function void report(string msg);
      errors++;
      $display("mismatch @%0t: %s", $realtime, msg);
    endfunction

    // Largest counter among ready slots, lowest slot on ties; -1 when none is ready.
    function int best_ready(output logic [CntW-1:0] top);
      int chosen;
      chosen = -1;
      top = '0;
      for (int i = 0; i < NumSlots; i++) begin
        if (valid_tab[i] && status_tab[i] == ST_READY && (chosen < 0 || cnt_tab[i] > top)) begin
          top = cnt_tab[i];
          chosen = i;
        end
      end
      return chosen;
    endfunction

    function void pick_next(input logic [TimeW-1:0] now, output bit rech, output bit idle);
      int chosen;
      logic [CntW-1:0] top;
      for (int i = 0; i < NumSlots; i++) begin
        if (valid_tab[i] && status_tab[i] == ST_SLEEP && now > wake_tab[i]) begin
          status_tab[i] = ST_READY;
        end
      end
      rech = 1'b0;
      idle = 1'b0;
      chosen = best_ready(top);
      if (chosen >= 0 && top == 0) begin
        // Recharge once; the second pick stands even if it is still zero.
        for (int i = 0; i < NumSlots; i++) begin
          if (valid_tab[i] && status_tab[i] != ST_EXITED) begin
            cnt_tab[i] = CntW'({1'b0, prio_tab[i]} + (cnt_tab[i] >> 1));
          end
        end
        rech = 1'b1;
        chosen = best_ready(top);
      end
      if (chosen < 0) begin
        idle = 1'b1;
        cur_slot = '0;
        if (valid_tab[0]) begin
          status_tab[0] = ST_RUNNING;
        end
      end else begin
        cur_slot = SlotFieldW'(chosen);
        status_tab[chosen] = ST_RUNNING;
      end
    endfunction

    function void note_request(req_t r);
      res_t want;
      bit   sched, rech, idle;
      sched = 1'b0;
      rech  = 1'b0;
      idle  = 1'b0;
      case (r.req_type)
        REQ_TICK: begin
          if (valid_tab[cur_slot]) begin
            if (cnt_tab[cur_slot] > 1) begin
              cnt_tab[cur_slot] = cnt_tab[cur_slot] - 1'b1;
            end else begin
              cnt_tab[cur_slot] = '0;
              status_tab[cur_slot] = ST_SLEEP;
              sched = 1'b1;
            end
          end
        end
        REQ_SLEEP: begin
          if (valid_tab[cur_slot]) begin
            wake_tab[cur_slot] = r.now_ms + 32'(MsPerSec) * 32'(r.sleep_seconds);
            status_tab[cur_slot] = ST_SLEEP;
            sched = 1'b1;
          end
        end
        REQ_YIELD: sched = 1'b1;
        REQ_INSTALL: begin
          if (r.slot < NumSlots) begin
            valid_tab[r.slot]  = 1'b1;
            status_tab[r.slot] = ST_READY;
            prio_tab[r.slot]   = r.task_priority;
            cnt_tab[r.slot]    = CntW'(r.task_priority);
            wake_tab[r.slot]   = '0;
          end
        end
        REQ_EXIT: begin
          if (r.slot < NumSlots) begin
            status_tab[r.slot] = ST_EXITED;
          end
        end
        default: ;
      endcase
      if (sched) begin
        pick_next(r.now_ms, rech, idle);
      end
      want.switched      = sched;
      want.next_slot     = cur_slot;
      want.next_counter  = valid_tab[cur_slot] ? cnt_tab[cur_slot] : '0;
      want.recomputed    = rech;
      want.idle_fallback = idle;
      decisions += sched;
      recharges += rech;
      idles     += idle;
      noted++;
      expected_q.push_back(want);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        report($sformatf("result %0d %s: expected %0h, got %0h", checked, name, want, got));
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with no pending request: %h", got));
        return;
      end
      want = expected_q.pop_front();
      compare_field("switched", want.switched, got.switched);
      compare_field("next_slot", want.next_slot, got.next_slot);
      compare_field("next_counter", want.next_counter, got.next_counter);
      compare_field("recomputed", want.recomputed, got.recomputed);
      compare_field("idle_fallback", want.idle_fallback, got.idle_fallback);
      checked++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  req_t in_data = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  res_t out_data_o;

  sched_scoreboard sb;
  int unsigned     cycle_cnt = 0;
  int unsigned     burst_left = 0;
  logic [31:0]     sim_ms = '0;
  bit              long_hold = 1'b0;

  priority_timeslice_scheduler i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && in_valid && in_ready_o) begin
      sb.note_request(in_data);
    end
    if (rst_ni && out_valid_o && out_ready) begin
      sb.check_result(out_data_o);
    end
  end

  initial begin : watchdog
    wait (cycle_cnt >= CycleLimit);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             sb.expected_q.size());
    $display("FAIL");
    $finish;
  end

  // Receiver: stretches of different stall patterns, plus one long hold-off on request.
  initial begin : receiver
    rx_mode_e mode;
    int unsigned span;
    forever begin
      if (long_hold) begin
        @(negedge clk_i);
        out_ready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        long_hold = 1'b0;
      end
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 150);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          RX_FREE:   out_ready <= 1'b1;
          RX_MOSTLY: out_ready <= ($urandom_range(0, 9) < 7);
          RX_SPARSE: out_ready <= ($urandom_range(0, 9) < 2);
          default:   out_ready <= (cycle_cnt[1:0] == 2'd0);
        endcase
      end
    end
  end

  function automatic req_t make_req(logic [2:0] kind, logic [31:0] now, logic [3:0] slot,
                                    logic [7:0] prio, logic [15:0] secs);
    req_t r;
    r.req_type      = kind;
    r.now_ms        = now;
    r.slot          = slot;
    r.task_priority = prio;
    r.sleep_seconds = secs;
    return r;
  endfunction

  // Mostly well-formed traffic on a forward-running clock, with occasional time jumps.
  function automatic req_t rand_req();
    req_t r;
    int unsigned pick;
    r.slot          = 4'($urandom());
    r.task_priority = 8'($urandom());
    r.sleep_seconds = 16'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 45)      r.req_type = REQ_TICK;
    else if (pick < 55) r.req_type = REQ_SLEEP;
    else if (pick < 70) r.req_type = REQ_YIELD;
    else if (pick < 85) r.req_type = REQ_INSTALL;
    else if (pick < 93) r.req_type = REQ_EXIT;
    else                r.req_type = 3'($urandom_range(ReqFirstUnused, ReqLastCode));
    if (r.req_type == REQ_INSTALL && $urandom_range(0, 9) < 8) begin
      r.task_priority = 8'($urandom_range(1, 6));
    end
    if (r.req_type == REQ_SLEEP && $urandom_range(0, 19) < 17) begin
      r.sleep_seconds = 16'($urandom_range(0, 2));
    end
    if ($urandom_range(0, 99) < 4) sim_ms = $urandom();
    else                           sim_ms = sim_ms + $urandom_range(0, 700);
    r.now_ms = sim_ms;
    return r;
  endfunction

  // Offer one transaction; bursts of random length are separated by random gaps.
  task automatic drive_item(input req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  initial begin : stimulus
    sb = new();
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty table: tick and sleep on an invalid current slot, yield into idle fallback.
    drive_item(make_req(REQ_TICK, 32'd0, 4'd0, 8'd0, 16'd0));
    drive_item(make_req(REQ_SLEEP, 32'd10, 4'd0, 8'd0, 16'd5));
    drive_item(make_req(REQ_YIELD, 32'd20, 4'd0, 8'd0, 16'd0));
    for (int k = ReqFirstUnused; k <= ReqLastCode; k++) begin
      drive_item(make_req(3'(k), '1, '1, '1, '1));
    end
    drive_item(make_req(REQ_INSTALL, 32'd30, 4'd0, 8'd0, 16'd0));
    drive_item(make_req(REQ_INSTALL, 32'd40, 4'd15, 8'd255, 16'hFFFF));
    drive_item(make_req(REQ_INSTALL, 32'd50, 4'd7, 8'd1, 16'd0));
    drive_item(make_req(REQ_YIELD, 32'd100, 4'd0, 8'd0, 16'd0));
    drive_item(make_req(REQ_TICK, 32'd110, 4'd0, 8'd0, 16'd0));
    // Sleep zero seconds: waking needs now strictly past the wake-up time.
    drive_item(make_req(REQ_SLEEP, 32'd200, 4'd0, 8'd0, 16'd0));
    // Expire slot 7 while only zero-counter slots are ready: the recharge lifts slot 7 to one.
    drive_item(make_req(REQ_TICK, 32'd200, 4'd0, 8'd0, 16'd0));
    drive_item(make_req(REQ_YIELD, 32'd201, 4'd0, 8'd0, 16'd0));
    drive_item(make_req(REQ_EXIT, 32'd210, 4'd15, 8'd0, 16'd0));
    drive_item(make_req(REQ_EXIT, 32'd220, 4'd9, 8'd0, 16'd0));
    // Wake-up time wraps past the top of the clock.
    drive_item(make_req(REQ_SLEEP, 32'hFFFF_FF00, 4'd0, 8'd0, 16'hFFFF));
    drive_item(make_req(REQ_INSTALL, '1, 4'd9, 8'hAA, 16'h5555));
    drive_item(make_req(REQ_TICK, '1, 4'd0, 8'd0, 16'd0));
    drive_item(make_req(REQ_EXIT, 32'd0, 4'd0, 8'd0, 16'd0));
    drive_item(make_req(REQ_EXIT, 32'd0, 4'd7, 8'd0, 16'd0));
    drive_item(make_req(REQ_EXIT, 32'd0, 4'd9, 8'd0, 16'd0));
    drive_item(make_req(REQ_YIELD, 32'd0, 4'd0, 8'd0, 16'd0));

    for (int n = 0; n < RandomItems; n++) begin
      if (n == 300) begin
        long_hold = 1'b1;
      end
      drive_item(rand_req());
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("ran %0d requests in %0d cycles: %0d scheduling decisions, %0d recharges,",
             sb.noted, cycle_cnt, sb.decisions, sb.recharges);
    $display("%0d idle fallbacks; %0d results checked, %0d mismatches",
             sb.idles, sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
